FILE: hdl/pbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbu_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned PROD_W  = 2 * CHAN_W;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned PICK_W  = 3;

	localparam logic [CHAN_W-1:0] FULL = 8'd255;

	localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MASK     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ALPHA    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd5;

	localparam logic [0:0] REG_BLEND_MODE   = 1'd0;
	localparam logic [0:0] REG_GLOBAL_ALPHA = 1'd1;

	localparam logic [PICK_W-1:0] PICK_DST  = 3'd0;
	localparam logic [PICK_W-1:0] PICK_SRC  = 3'd1;
	localparam logic [PICK_W-1:0] PICK_LERP = 3'd2;
	localparam logic [PICK_W-1:0] PICK_ADD  = 3'd3;
	localparam logic [PICK_W-1:0] PICK_SUB  = 3'd4;
	localparam logic [PICK_W-1:0] PICK_MUL  = 3'd5;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pix_t;

	typedef struct packed {
		logic              en_s3;
		logic              en_s4;
		logic              en_s5;
		logic              en_s6;
		logic [PICK_W-1:0] pick_s5;
	} chan_ctl_t;

	// exact floor(x / 255) for x <= 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]};
		return t[PROD_W-1:CHAN_W];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/pbu_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pbu_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;
	logic [7:0] dst_red;
	logic [7:0] dst_green;
	logic [7:0] dst_blue;
	logic [7:0] dst_alpha;

	modport source (
		output valid, src_red, src_green, src_blue, src_alpha,
		       dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, src_red, src_green, src_blue, src_alpha,
		       dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);
endinterface

interface pbu_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/pbu_channel.sv
`timescale 1ns / 1ps
`default_nettype none

module pbu_channel (
	input  wire logic                       clk,
	input  wire pbu_pkg::chan_ctl_t         ctl,
	input  wire logic [pbu_pkg::CHAN_W-1:0] src,
	input  wire logic [pbu_pkg::CHAN_W-1:0] dst,
	input  wire logic [pbu_pkg::CHAN_W-1:0] beta,
	output logic      [pbu_pkg::CHAN_W-1:0] res
);

	localparam int unsigned CW = pbu_pkg::CHAN_W;
	localparam int unsigned PW = pbu_pkg::PROD_W;

	logic [PW-1:0] sb_s3, dn_s3;
	logic [CW-1:0] s_s3, d_s3;
	logic [CW-1:0] t_s4, s_s4, d_s4;
	logic [PW-1:0] lsum_s4;
	logic [CW-1:0] lerp_s5, add_s5, sub_s5, s_s5, d_s5;
	logic [PW-1:0] mp_s5;
	logic [CW-1:0] res_s6;

	logic [CW:0]   add_sum;
	logic [PW:0]   lsum_full;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sb_s3 <= src * beta;
			dn_s3 <= dst * (pbu_pkg::FULL - beta);
			s_s3  <= src;
			d_s3  <= dst;
		end
	end

	assign lsum_full = {1'b0, sb_s3} + {1'b0, dn_s3};

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			t_s4    <= pbu_pkg::div255(sb_s3);
			lsum_s4 <= lsum_full[PW-1:0];
			s_s4    <= s_s3;
			d_s4    <= d_s3;
		end
	end

	assign add_sum = {1'b0, d_s4} + {1'b0, t_s4};

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			lerp_s5 <= pbu_pkg::div255(lsum_s4);
			mp_s5   <= d_s4 * t_s4;
			add_s5  <= add_sum[CW] ? pbu_pkg::FULL : add_sum[CW-1:0];
			sub_s5  <= (t_s4 > d_s4) ? '0 : d_s4 - t_s4;
			s_s5    <= s_s4;
			d_s5    <= d_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s6) begin
			case (ctl.pick_s5)
				pbu_pkg::PICK_SRC:  res_s6 <= s_s5;
				pbu_pkg::PICK_LERP: res_s6 <= lerp_s5;
				pbu_pkg::PICK_ADD:  res_s6 <= add_s5;
				pbu_pkg::PICK_SUB:  res_s6 <= sub_s5;
				pbu_pkg::PICK_MUL:  res_s6 <= pbu_pkg::div255(mp_s5);
				default:            res_s6 <= d_s5;
			endcase
		end
	end

	assign res = res_s6;

endmodule

`default_nettype wire

FILE: hdl/pixel_blend_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one pixel per clock while the result side is ready;
// each of the six stages holds its own valid bit, so a stall only
// backs up stages that are occupied.
// Reset: arst_n clears all valid bits, blend_mode to alpha (2) and
// global_alpha to 255; datapath registers are not reset.
module pixel_blend_unit_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	pbu_pix_in_if.sink       pixel,
	pbu_pix_out_if.source    result
);

	localparam int unsigned CW = pbu_pkg::CHAN_W;
	localparam int unsigned PW = pbu_pkg::PROD_W;
	localparam int unsigned NS = 6;

	logic [pbu_pkg::MODE_W-1:0] blend_mode_q;
	logic [CW-1:0]              global_alpha_q;

	logic [NS:1] v;
	logic [NS:1] en;

	pbu_pkg::pix_t              src_s1, dst_s1, src_s2, dst_s2;
	logic [pbu_pkg::MODE_W-1:0] mode_s1, mode_s2;
	logic [PW-1:0]              pa_s1;
	logic [CW-1:0]              beta_s2;
	logic [pbu_pkg::PICK_W-1:0] pick_s3, pick_s4, pick_s5;
	logic [CW-1:0]              alpha_s3, alpha_s4, alpha_s5, alpha_s6;
	logic [pbu_pkg::PICK_W-1:0] pick_c;
	logic [CW-1:0]              alpha_c;
	pbu_pkg::chan_ctl_t         ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q   <= pbu_pkg::MODE_ALPHA;
			global_alpha_q <= pbu_pkg::FULL;
		end else if (cfg_we) begin
			case (cfg_index)
				pbu_pkg::REG_BLEND_MODE:   blend_mode_q   <= cfg_wdata[pbu_pkg::MODE_W-1:0];
				pbu_pkg::REG_GLOBAL_ALPHA: global_alpha_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the next one moves
	always_comb begin
		en[NS] = !v[NS] || result.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !v[k] || en[k+1];
		end
	end

	assign pixel.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1]) v[1] <= pixel.valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) v[k] <= v[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			src_s1  <= '{pixel.src_red, pixel.src_green, pixel.src_blue, pixel.src_alpha};
			dst_s1  <= '{pixel.dst_red, pixel.dst_green, pixel.dst_blue, pixel.dst_alpha};
			mode_s1 <= blend_mode_q;
			pa_s1   <= pixel.src_alpha * global_alpha_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
			mode_s2 <= mode_s1;
			beta_s2 <= pbu_pkg::div255(pa_s1);
		end
	end

	always_comb begin
		pick_c  = pbu_pkg::PICK_DST;
		alpha_c = dst_s2.alpha;
		case (mode_s2)
			pbu_pkg::MODE_NONE: begin
				pick_c  = pbu_pkg::PICK_SRC;
				alpha_c = beta_s2;
			end
			pbu_pkg::MODE_MASK: begin
				alpha_c = src_s2.alpha;
			end
			pbu_pkg::MODE_ALPHA: begin
				if (beta_s2 == '0) begin
					pick_c = pbu_pkg::PICK_DST;
				end else if (beta_s2 == pbu_pkg::FULL || dst_s2.alpha == '0) begin
					pick_c  = pbu_pkg::PICK_SRC;
					alpha_c = beta_s2;
				end else begin
					pick_c  = pbu_pkg::PICK_LERP;
					alpha_c = (dst_s2.alpha < beta_s2) ? beta_s2 : dst_s2.alpha;
				end
			end
			pbu_pkg::MODE_ADD:      pick_c = pbu_pkg::PICK_ADD;
			pbu_pkg::MODE_SUBTRACT: pick_c = pbu_pkg::PICK_SUB;
			pbu_pkg::MODE_MULTIPLY: pick_c = pbu_pkg::PICK_MUL;
			default:                pick_c = pbu_pkg::PICK_DST;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pick_s3  <= pick_c;
			alpha_s3 <= alpha_c;
		end
		if (en[4]) begin
			pick_s4  <= pick_s3;
			alpha_s4 <= alpha_s3;
		end
		if (en[5]) begin
			pick_s5  <= pick_s4;
			alpha_s5 <= alpha_s4;
		end
		if (en[6]) begin
			alpha_s6 <= alpha_s5;
		end
	end

	assign ctl = '{en_s3: en[3], en_s4: en[4], en_s5: en[5], en_s6: en[6], pick_s5: pick_s5};

	pbu_channel u_red (
		.clk  (clk),
		.ctl  (ctl),
		.src  (src_s2.red),
		.dst  (dst_s2.red),
		.beta (beta_s2),
		.res  (result.out_red)
	);

	pbu_channel u_green (
		.clk  (clk),
		.ctl  (ctl),
		.src  (src_s2.green),
		.dst  (dst_s2.green),
		.beta (beta_s2),
		.res  (result.out_green)
	);

	pbu_channel u_blue (
		.clk  (clk),
		.ctl  (ctl),
		.src  (src_s2.blue),
		.dst  (dst_s2.blue),
		.beta (beta_s2),
		.res  (result.out_blue)
	);

	assign result.valid     = v[NS];
	assign result.out_alpha = alpha_s6;

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> pixel.ready)
		else $error("ready chain broken");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v[1])
		else $error("accepted request not in first stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v[NS] && !result.ready && v[NS-1]) |=> (v[NS-1] && $stable(pick_s5)))
		else $error("stalled stage lost its item");

	a_beta_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v[2] |-> (beta_s2 <= src_s2.alpha))
		else $error("effective alpha exceeds source alpha");

endmodule

`default_nettype wire
